@@ rtl/core/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, constants and character helpers for the radix string to
// integer converter.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // field widths
  localparam int CH_W       = 8;
  localparam int RADIX_W    = 6;
  localparam int VALUE_W    = 64;
  localparam int CONSUMED_W = 13;
  localparam int DIGIT_W    = 6;
  localparam int PROD_W     = VALUE_W + RADIX_W;

  // default character limit for the consumed counter
  localparam int MAX_CHARS_DEF = 4096;

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_RADIX = 1'b0;
  localparam logic [RADIX_W-1:0]   RADIX_RST = 6'd10;

  // bases
  localparam logic [RADIX_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_EIGHT = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_TEN   = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_SIXTN = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_ONE   = 6'd1;

  // characters
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;

  // digit code for a character that is no digit in any base
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  // signed 64-bit limits
  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // parse phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  // base update selection
  typedef enum logic [1:0] {
    BSEL_KEEP,
    BSEL_OCT,
    BSEL_DEC,
    BSEL_HEX
  } base_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      clear;
    base_sel_e base_sel;
    logic      set_sign;
    logic      count;
    logic      accumulate;
    logic      emit;
  } rsi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic radix_bad;
    logic is_space;
    logic is_sign;
    logic is_zero;
    logic is_x;
    logic base_auto;
    logic base_auto_or_hex;
    logic digit_ok;
    logic out_full;
  } rsi_sts_t;

  // c-locale whitespace
  function automatic logic is_space_f(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // digit value 0..35, or DIGIT_NONE
  function automatic logic [DIGIT_W-1:0] digit_of_f(logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    d = '0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = c - CH_ZERO;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      d = c - CH_LO_A + CH_W'(DIGIT_TEN);
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      d = c - CH_UP_A + CH_W'(DIGIT_TEN);
    end else begin
      d = CH_W'(DIGIT_NONE);
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

@@ rtl/core/rsi_in_if.sv @@
// ----------------------------------------------------------------------------
// rsi_in_if
// Character channel: one ASCII character and a start-of-string mark per beat.
// ----------------------------------------------------------------------------
interface rsi_in_if import rsi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            start_req;

  modport source (output valid, ch, start_req, input ready);
  modport sink (input valid, ch, start_req, output ready);
endinterface

@@ rtl/core/rsi_out_if.sv @@
// ----------------------------------------------------------------------------
// rsi_out_if
// Result channel: parsed value, consumed count and range flag per beat.
// ----------------------------------------------------------------------------
interface rsi_out_if import rsi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [CONSUMED_W-1:0]     consumed;
  logic                      range_error;

  modport source (output valid, value, consumed, range_error, input ready);
  modport sink (input valid, value, consumed, range_error, output ready);
endinterface

@@ rtl/core/radix_string_to_integer.sv @@
// ----------------------------------------------------------------------------
// radix_string_to_integer
// Streaming string to signed 64-bit integer converter with a configurable
// radix (2..36 or automatic), C-locale whitespace, sign and 0x prefix.
//
//   channel  dir  beat contents                       handshake
//   in_i     in   ch, start_req                       valid / ready
//   out_o    out  value, consumed, range_error        valid / ready
//   apb      in   radix register at byte address 0    psel / penable
//
// One character per clock; the multiply-add of the accumulator and its limit
// compare are combinational. The terminating character loads the
// result register, and while that result waits the next character is held off.
// Input stalls only while the result register is full and not being taken.
// Reset clears the parse to idle and sets the radix to ten.
// ----------------------------------------------------------------------------
module radix_string_to_integer import rsi_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rsi_in_if.sink             in_i,
  rsi_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [RADIX_W-1:0]   radix_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  rsi_cmd_t             cmd;
  rsi_sts_t             sts;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_RADIX);
  assign prdata  = (reg_idx == REG_RADIX) ? PDATA_W'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RST;
    end else if (cfg_wr) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  // parse controller
  rsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .start_req_i (in_i.start_req),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // datapath and result register
  rsi_dpath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .radix_i           (radix_q),
    .ch_i              (in_i.ch),
    .start_req_i       (in_i.start_req),
    .cmd_i             (cmd),
    .out_ready_i       (out_o.ready),
    .sts_o             (sts),
    .out_valid_o       (out_o.valid),
    .out_value_o       (out_o.value),
    .out_consumed_o    (out_o.consumed),
    .out_range_error_o (out_o.range_error)
  );

endmodule

@@ rtl/core/rsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsi_ctrl
// Parse state machine: walks whitespace, sign, prefix and digit phases and
// issues one command word per accepted character.
// ----------------------------------------------------------------------------
module rsi_ctrl import rsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     start_req_i,
  input  logic     out_ready_i,
  input  rsi_sts_t sts_i,
  output logic     in_ready_o,
  output rsi_cmd_t cmd_o
);

  phase_e phase_q, phase_d;
  logic   fire;

  // a beat is taken whenever the result register has room
  assign in_ready_o = !sts_i.out_full || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // next state and commands; a character may fall through several phases
  always_comb begin
    phase_e ph;
    logic   done;
    phase_d = phase_q;
    cmd_o   = '0;
    ph      = phase_q;
    done    = 1'b0;
    if (fire) begin
      if (start_req_i) begin
        cmd_o.clear = 1'b1;
        ph          = PH_LEAD;
        if (sts_i.radix_bad) begin
          cmd_o.emit = 1'b1;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end
      end
      if (ph == PH_IDLE) begin
        done = 1'b1;
      end
      // leading whitespace and sign
      if (!done && ph == PH_LEAD) begin
        if (sts_i.is_space) begin
          cmd_o.count = 1'b1;
          phase_d     = PH_LEAD;
          done        = 1'b1;
        end else if (sts_i.is_sign) begin
          cmd_o.set_sign = 1'b1;
          cmd_o.count    = 1'b1;
          phase_d        = PH_PREFIX;
          done           = 1'b1;
        end else begin
          ph = PH_PREFIX;
        end
      end
      // leading zero of a prefix
      if (!done && ph == PH_PREFIX) begin
        if (sts_i.is_zero && sts_i.base_auto_or_hex) begin
          if (sts_i.base_auto) begin
            cmd_o.base_sel = BSEL_OCT;
          end
          cmd_o.count = 1'b1;
          phase_d     = PH_ZERO;
          done        = 1'b1;
        end else begin
          if (sts_i.base_auto) begin
            cmd_o.base_sel = BSEL_DEC;
          end
          ph = PH_DIGITS;
        end
      end
      // x after the zero
      if (!done && ph == PH_ZERO) begin
        if (sts_i.is_x) begin
          cmd_o.base_sel = BSEL_HEX;
          cmd_o.count    = 1'b1;
          phase_d        = PH_DIGITS;
          done           = 1'b1;
        end else begin
          ph = PH_DIGITS;
        end
      end
      // digit collection
      if (!done && ph == PH_DIGITS) begin
        if (sts_i.digit_ok) begin
          cmd_o.count      = 1'b1;
          cmd_o.accumulate = 1'b1;
          phase_d          = PH_DIGITS;
        end else begin
          cmd_o.emit = 1'b1;
          phase_d    = PH_IDLE;
        end
      end
    end
  end

  // a result only comes from an accepted beat
  a_emit_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> fire)
    else $error("result issued without an accepted beat");

  // a result ends the parse
  a_emit_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> phase_q == PH_IDLE)
    else $error("parse still active after its result");

endmodule

@@ rtl/core/rsi_dpath.sv @@
// ----------------------------------------------------------------------------
// rsi_dpath
// Character decode, base, sign, magnitude accumulator with overflow check,
// saturating character counter and the result register.
// ----------------------------------------------------------------------------
module rsi_dpath import rsi_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [RADIX_W-1:0]        radix_i,
  input  logic [CH_W-1:0]           ch_i,
  input  logic                      start_req_i,
  input  rsi_cmd_t                  cmd_i,
  input  logic                      out_ready_i,
  output rsi_sts_t                  sts_o,
  output logic                      out_valid_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic [CONSUMED_W-1:0]     out_consumed_o,
  output logic                      out_range_error_o
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  logic                 neg_q, neg_d;
  logic [RADIX_W-1:0]   base_q, base_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;

  logic                 out_valid_q;
  logic [VALUE_W-1:0]   out_value_q;
  logic [CONSUMED_W-1:0] out_consumed_q;
  logic                 out_range_error_q;

  logic                 neg_cur, ovf_cur;
  logic [RADIX_W-1:0]   base_cur, base_eff;
  logic [VALUE_W-1:0]   mag_cur, limit, result_value;
  logic [CNT_W-1:0]     cnt_cur, cnt_inc;
  logic [DIGIT_W-1:0]   digit;
  logic [PROD_W-1:0]    acc;
  logic                 acc_over;

  // state as seen by this beat: a start beat sees fresh state
  assign neg_cur  = start_req_i ? 1'b0 : neg_q;
  assign ovf_cur  = start_req_i ? 1'b0 : ovf_q;
  assign base_cur = start_req_i ? radix_i : base_q;
  assign mag_cur  = start_req_i ? '0 : mag_q;
  assign cnt_cur  = start_req_i ? '0 : cnt_q;
  assign base_eff = (base_cur == BASE_AUTO) ? BASE_TEN : base_cur;

  // character decode
  assign digit = digit_of_f(ch_i);

  assign sts_o.radix_bad        = (radix_i == BASE_ONE) || (radix_i > BASE_MAX);
  assign sts_o.is_space         = is_space_f(ch_i);
  assign sts_o.is_sign          = (ch_i == CH_PLUS) || (ch_i == CH_MINUS);
  assign sts_o.is_zero          = (ch_i == CH_ZERO);
  assign sts_o.is_x             = (ch_i == CH_LO_X) || (ch_i == CH_UP_X);
  assign sts_o.base_auto        = (base_cur == BASE_AUTO);
  assign sts_o.base_auto_or_hex = (base_cur == BASE_AUTO) || (base_cur == BASE_SIXTN);
  assign sts_o.digit_ok         = (digit < base_eff);
  assign sts_o.out_full         = out_valid_q;

  // multiply-add and limit check; m*b+d > limit matches the divided form
  assign limit    = neg_cur ? NEG_LIMIT : POS_LIMIT;
  assign acc      = PROD_W'(mag_cur) * PROD_W'(base_eff) + PROD_W'(digit);
  assign acc_over = acc > PROD_W'(limit);

  // saturating character count
  assign cnt_inc = (cnt_cur < CNT_W'(MAX_CHARS)) ? cnt_cur + CNT_W'(1) : cnt_cur;

  // final value with saturation
  always_comb begin
    if (ovf_cur) begin
      result_value = neg_cur ? NEG_LIMIT : POS_LIMIT;
    end else begin
      result_value = neg_cur ? (VALUE_W'(0) - mag_cur) : mag_cur;
    end
  end

  // next parse state
  always_comb begin
    neg_d = cmd_i.clear ? 1'b0 : neg_q;
    ovf_d = cmd_i.clear ? 1'b0 : ovf_q;
    mag_d = cmd_i.clear ? '0 : mag_q;
    cnt_d = cmd_i.clear ? '0 : cnt_q;
    base_d = cmd_i.clear ? radix_i : base_q;
    if (cmd_i.set_sign) begin
      neg_d = (ch_i == CH_MINUS);
    end
    if (cmd_i.count) begin
      cnt_d = cnt_inc;
    end
    case (cmd_i.base_sel)
      BSEL_KEEP: ;
      BSEL_OCT:  base_d = BASE_EIGHT;
      BSEL_DEC:  base_d = BASE_TEN;
      BSEL_HEX:  base_d = BASE_SIXTN;
      default:   ;
    endcase
    if (cmd_i.accumulate && !ovf_cur) begin
      if (acc_over) begin
        ovf_d = 1'b1;
      end else begin
        mag_d = acc[VALUE_W-1:0];
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
      mag_q  <= '0;
      cnt_q  <= '0;
      base_q <= '0;
    end else begin
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
      mag_q  <= mag_d;
      cnt_q  <= cnt_d;
      base_q <= base_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q       <= result_value;
      out_consumed_q    <= CONSUMED_W'(cnt_cur);
      out_range_error_q <= ovf_cur;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_value_o       = out_value_q;
  assign out_consumed_o    = out_consumed_q;
  assign out_range_error_o = out_range_error_q;

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  // magnitude stays within the negative limit until overflow
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovf_q |-> (mag_q <= NEG_LIMIT))
    else $error("magnitude past range without overflow flag");

  // range flag comes with a saturated value
  a_range_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_range_error_q) |->
      (out_value_q == POS_LIMIT || out_value_q == NEG_LIMIT))
    else $error("range flag with unsaturated value");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix string to integer converter. Strings are
// streamed one character per beat and predicted character by character by a
// local parser model. Results are compared field by field in order, and the
// radix register is swept over auto, the usable bases and the unusable codes,
// with random idling on both channels and a long result back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import rsi_pkg::*;

  localparam int CHAR_LIMIT    = MAX_CHARS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_BUDGET = 95;
  localparam int BAD_BUDGET    = 30;
  localparam int NUM_PHASES    = 14;
  localparam int NOT_A_DIGIT   = 99;
  localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'({REG_RADIX, 2'b00});

  // one character beat
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            starts;
  } char_beat_t;

  // one parse result
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CONSUMED_W-1:0]     consumed;
    logic                      range_error;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rsi_in_if  in_bus ();
  rsi_out_if out_bus ();

  radix_string_to_integer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and expectation stores
  char_beat_t   pending_chars [$];
  conv_result_t expected_results [$];
  char_beat_t   cur_beat;
  conv_result_t drv_result;

  // parser model state
  logic [RADIX_W-1:0]    cfg_radix = BASE_TEN;
  phase_e                ps_phase = PH_IDLE;
  logic                  ps_neg = 1'b0;
  logic [RADIX_W-1:0]    ps_base = '0;
  logic [VALUE_W-1:0]    ps_mag = '0;
  logic [CONSUMED_W-1:0] ps_count = '0;
  logic                  ps_ovf = 1'b0;

  // idling control
  int   send_wait = 0;
  int   recv_wait = 0;
  int   send_mode = 1;
  int   recv_mode = 1;
  bit   modes_locked = 1'b0;
  bit   hold_go = 1'b0;
  logic hold_recv = 1'b0;

  // bookkeeping
  int cycle_count = 0;
  int chars_queued = 0;
  int chars_accepted = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int radix_writes = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------- model

  function automatic bit is_blank(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned char_value(logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic void bump_count();
    if (ps_count < CHAR_LIMIT) ps_count = ps_count + 1'b1;
  endfunction

  // advance the parser by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [CH_W-1:0] c, input logic starts,
                                    output conv_result_t res);
    int unsigned        dv;
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] b;
    res = '0;
    if (starts) begin
      ps_neg   = 1'b0;
      ps_mag   = '0;
      ps_count = '0;
      ps_ovf   = 1'b0;
      ps_base  = cfg_radix;
      if (ps_base == BASE_ONE || ps_base > BASE_MAX) begin
        ps_phase = PH_IDLE;
        return 1'b1;
      end
      ps_phase = PH_LEAD;
    end
    if (ps_phase == PH_IDLE) return 1'b0;
    // a character can fall through at most three phases
    for (int step = 0; step < 4; step++) begin
      case (ps_phase)
        PH_LEAD: begin
          if (is_blank(c)) begin
            bump_count();
            return 1'b0;
          end
          ps_phase = PH_PREFIX;
          if (c == CH_PLUS || c == CH_MINUS) begin
            ps_neg = (c == CH_MINUS);
            bump_count();
            return 1'b0;
          end
        end
        PH_PREFIX: begin
          if (c == CH_ZERO && (ps_base == BASE_AUTO || ps_base == BASE_SIXTN)) begin
            if (ps_base == BASE_AUTO) ps_base = BASE_EIGHT;
            bump_count();
            ps_phase = PH_ZERO;
            return 1'b0;
          end
          if (ps_base == BASE_AUTO) ps_base = BASE_TEN;
          ps_phase = PH_DIGITS;
        end
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            ps_base = BASE_SIXTN;
            bump_count();
            ps_phase = PH_DIGITS;
            return 1'b0;
          end
          ps_phase = PH_DIGITS;
        end
        default: begin
          dv = char_value(c);
          b  = VALUE_W'(ps_base);
          if (dv >= b) begin
            if (ps_ovf) res.value = ps_neg ? NEG_LIMIT : POS_LIMIT;
            else res.value = ps_neg ? ('0 - ps_mag) : ps_mag;
            res.consumed    = ps_count;
            res.range_error = ps_ovf;
            ps_phase = PH_IDLE;
            return 1'b1;
          end
          bump_count();
          if (!ps_ovf) begin
            lim = ps_neg ? NEG_LIMIT : POS_LIMIT;
            if (ps_mag > (lim - VALUE_W'(dv)) / b) ps_ovf = 1'b1;
            else ps_mag = ps_mag * b + VALUE_W'(dv);
          end
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- idling

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  // receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_go);
    hold_recv <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_recv <= 1'b0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.ch        <= '0;
      in_bus.start_req <= 1'b0;
      send_wait = 0;
    end else begin
      // accepted character beat
      if (in_bus.valid && in_bus.ready) begin
        chars_accepted++;
        if (parse_char(cur_beat.ch, cur_beat.starts, drv_result))
          expected_results.push_back(drv_result);
        send_wait = draw_wait(send_mode);
        if (!modes_locked && $urandom_range(0, 63) == 0) send_mode = $urandom_range(0, 2);
      end
      // present the next beat
      if (!in_bus.valid || in_bus.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_bus.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          cur_beat = pending_chars.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.ch        <= cur_beat.ch;
          in_bus.start_req <= cur_beat.starts;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_result();
    conv_result_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: value %0d consumed %0d range_error %0b",
                 out_bus.value, out_bus.consumed, out_bus.range_error);
    end else begin
      want = expected_results.pop_front();
      if (out_bus.value != want.value || out_bus.consumed != want.consumed ||
          out_bus.range_error != want.range_error) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: exp value %0d consumed %0d range_error %0b, got %0d %0d %0b",
                   results_checked, want.value, want.consumed, want.range_error,
                   out_bus.value, out_bus.consumed, out_bus.range_error);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_result();
        recv_wait = draw_wait(recv_mode);
        if (!modes_locked && $urandom_range(0, 63) == 0) recv_mode = $urandom_range(0, 2);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_bus.ready <= (recv_wait == 0) && !hold_recv;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic put_char(input logic [CH_W-1:0] c, input logic starts);
    char_beat_t b;
    b.ch     = c;
    b.starts = starts;
    pending_chars.push_back(b);
    chars_queued++;
  endtask

  task automatic put_text(input string s, input bit marked);
    for (int i = 0; i < s.len(); i++) put_char(s[i], marked && (i == 0));
  endtask

  function automatic logic [CH_W-1:0] digit_char(int unsigned d);
    if (d < 10) return CH_ZERO + CH_W'(d);
    if ($urandom_range(0, 1) != 0) return CH_LO_A + CH_W'(d - 10);
    return CH_UP_A + CH_W'(d - 10);
  endfunction

  function automatic logic [CH_W-1:0] blank_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : CH_W'(r);
  endfunction

  // one random string, mostly well formed for the current radix
  task automatic add_random_string();
    int                 kind;
    int                 start_idx;
    int unsigned        eff;
    logic [VALUE_W-1:0] target;
    logic [CH_W-1:0]    c;
    logic [CH_W-1:0]    digits [$];
    kind      = $urandom_range(0, 19);
    start_idx = pending_chars.size();
    eff       = (cfg_radix == BASE_AUTO || cfg_radix == BASE_ONE || cfg_radix > BASE_MAX) ?
                10 : cfg_radix;
    if (kind == 19) begin
      // raw noise with random start marks
      repeat ($urandom_range(1, 6)) put_char(CH_W'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    // leading blanks and sign
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_char(blank_char(), 1'b0);
    case ($urandom_range(0, 2))
      0: put_char(CH_PLUS, 1'b0);
      1: put_char(CH_MINUS, 1'b0);
      default: ;
    endcase
    // prefix where the base allows one
    if (cfg_radix == BASE_AUTO || cfg_radix == BASE_SIXTN) begin
      case ($urandom_range(0, 3))
        0: begin
          put_char(CH_ZERO, 1'b0);
          put_char(($urandom_range(0, 1) != 0) ? CH_LO_X : CH_UP_X, 1'b0);
          eff = 16;
        end
        1: if (cfg_radix == BASE_AUTO) begin
          put_char(CH_ZERO, 1'b0);
          eff = 8;
        end
        default: ;
      endcase
    end
    // digits: near the signed limits, long runs, or short numbers
    if (kind < 3) begin
      target = (($urandom_range(0, 1) != 0) ? POS_LIMIT : NEG_LIMIT) +
               VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
      while (target != 0) begin
        digits.push_front(digit_char(32'(target % VALUE_W'(eff))));
        target = target / VALUE_W'(eff);
      end
    end else begin
      repeat ((kind == 3) ? $urandom_range(20, 70) : $urandom_range(0, 10))
        digits.push_back(digit_char($urandom_range(0, eff - 1)));
    end
    foreach (digits[i]) put_char(digits[i], 1'b0);
    // terminator, left off now and then so the next start cuts the parse
    if (kind != 18) begin
      do c = CH_W'($urandom); while (char_value(c) < eff);
      put_char(c, 1'b0);
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) put_char(CH_W'($urandom), 1'b0);
    if (pending_chars.size() > start_idx) pending_chars[start_idx].starts = 1'b1;
  endtask

  // all beats taken, all results in, then let the block settle
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // radix register write followed by a readback
  task automatic write_radix(input logic [RADIX_W-1:0] val);
    logic [RADIX_W-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= (PDATA_W'($urandom) << RADIX_W) | PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_radix = val;
    radix_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata[RADIX_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got != val) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("radix readback: exp %0d, got %0d", val, got);
    end
  endtask

  function automatic logic [RADIX_W-1:0] radix_for_phase(int p);
    case (p)
      0: return BASE_TEN;
      1: return BASE_AUTO;
      2: return BASE_SIXTN;
      3: return 6'd2;
      4: return BASE_MAX;
      5: return 6'd37;
      6: return BASE_TEN;
      7: return BASE_EIGHT;
      8: return BASE_ONE;
      9: return BASE_AUTO;
      10: return 6'd63;
      11: return BASE_SIXTN;
      default: return RADIX_W'($urandom_range(2, 36));
    endcase
  endfunction

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int                 phase_start;
    logic [RADIX_W-1:0] rdx;
    in_bus.valid     = 1'b0;
    in_bus.ch        = '0;
    in_bus.start_req = 1'b0;
    out_bus.ready    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // base ten from reset: blanks, signs, no digits, idle and restart cases
    put_text(" \t-42", 1'b1); put_char(8'h00, 1'b0);
    put_text("+7x", 1'b1);
    put_text("-.", 1'b1);
    put_text("99", 1'b0);
    put_text("12", 1'b1); put_text("5", 1'b1); put_char(8'h00, 1'b0);
    put_char(8'hC8, 1'b1);
    put_text("31", 1'b1); put_char(8'hFF, 1'b0);
    // signed limits and just past them
    put_text("9223372036854775807", 1'b1); put_char(8'h00, 1'b0);
    put_text("-9223372036854775808", 1'b1); put_char(8'h00, 1'b0);
    put_text("9223372036854775808", 1'b1); put_char(8'h00, 1'b0);
    put_text("-9223372036854775809", 1'b1); put_text("77", 1'b0); put_char(8'h00, 1'b0);
    // radix changed while a string is open keeps the latched base
    put_text("12", 1'b1);
    wait_idle();
    write_radix(BASE_SIXTN);
    put_text("a", 1'b0);
    // hex prefix handling
    put_text("0x1F", 1'b1); put_char(CH_SPACE, 1'b0);
    put_text("0XfF;", 1'b1);
    put_text("0xg", 1'b1);
    put_text("-0x8000000000000000", 1'b1); put_char(8'h00, 1'b0);
    put_text("7fffffffffffffff0", 1'b1); put_char(8'h00, 1'b0);
    wait_idle();
    // automatic base
    write_radix(BASE_AUTO);
    put_text("0x1a", 1'b1); put_char(8'h00, 1'b0);
    put_text("017 ", 1'b1);
    put_text("0", 1'b1); put_char(8'h00, 1'b0);
    put_text("123", 1'b1); put_char(8'h00, 1'b0);
    put_text("0X", 1'b1); put_char(8'h00, 1'b0);
    put_text("08", 1'b1);
    wait_idle();
    write_radix(BASE_MAX);
    put_text("zZ", 1'b1); put_char(8'h00, 1'b0);
    put_text("-zzzzzzzzzzzzzz", 1'b1); put_char(8'h00, 1'b0);
    put_text("Zz{", 1'b1);
    wait_idle();
    write_radix(6'd2);
    put_text("1011", 1'b1); put_char(8'h00, 1'b0);
    put_text("-2", 1'b1);
    wait_idle();
    // unusable radix codes answer on the start character
    write_radix(BASE_ONE);
    put_text("5", 1'b1); put_text("55", 1'b0);
    wait_idle();
    write_radix(6'd37);
    put_text("7", 1'b1);
    wait_idle();
    write_radix(6'd63);
    put_text("x", 1'b1);
    wait_idle();
    send_mode = 1;
    recv_mode = 2;

    // random strings over a sweep of radix settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      rdx = radix_for_phase(p);
      write_radix(rdx);
      if (p == 6) begin
        // back-pressure: receiver holds off while characters keep coming
        modes_locked = 1'b1;
        send_mode = 0;
        hold_go = 1'b1;
      end
      phase_start = chars_queued;
      while (chars_queued - phase_start <
             ((rdx == BASE_ONE || rdx > BASE_MAX) ? BAD_BUDGET : RANDOM_BUDGET))
        add_random_string();
      wait_idle();
      modes_locked = 1'b0;
    end

    wait_idle();
    if (expected_results.size() != 0) mismatch_count++;
    $display("%0d characters taken, %0d results checked, %0d radix writes, %0d mismatches",
             chars_accepted, results_checked, radix_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rsi_pkg.sv
rtl/core/rsi_in_if.sv
rtl/core/rsi_out_if.sv
rtl/core/rsi_ctrl.sv
rtl/core/rsi_dpath.sv
rtl/core/radix_string_to_integer.sv
tb/tb_top.sv
